// ===== sv/ddt_pkg.sv =====
package ddt_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_OK_MASK        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_OK_MASK = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_DEL   = 2'd1,
    FN_SET   = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_OP    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_QRD,
    S_QOUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] id;
    logic [1:0]  size;
    logic [7:0]  hops;
    logic        master;
    logic [31:0] flags;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic wr_upd;
    logic wr_set;
    logic wr_new;
    logic res_full;
    logic res_nf;
    logic mv_init;
    logic shift_rd;
    logic shift_wr;
    logic dec;
    logic q_rd;
    logic q_out;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  scan_hit;
    logic  scan_miss;
    logic  full;
    logic  shift_more;
    logic  master_ok;
    logic  out_free;
  } sts_t;

endpackage

// ===== sv/ddt_in_if.sv =====
interface ddt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] comp_tag;
  logic [15:0] dest_id;
  logic [1:0]  id_size;
  logic [7:0]  hop_count;
  logic        is_master_port;
  logic [31:0] flags_in;

  modport source (output valid, func, comp_tag, dest_id, id_size, hop_count,
                  is_master_port, flags_in, input ready);
  modport sink (input valid, func, comp_tag, dest_id, id_size, hop_count,
                is_master_port, flags_in, output ready);
endinterface

// ===== sv/ddt_out_if.sv =====
interface ddt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_comp_tag;
  logic [15:0] out_dest_id;
  logic [1:0]  out_id_size;
  logic [31:0] out_flags;

  modport source (output valid, status, out_comp_tag, out_dest_id, out_id_size,
                  out_flags, input ready);
  modport sink (input valid, status, out_comp_tag, out_dest_id, out_id_size,
                out_flags, output ready);
endinterface

// ===== sv/ddt_ctrl.sv =====
module ddt_ctrl
  import ddt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // query skips the key search
        if (sts.func == FN_QUERY) begin
          state_nxt = sts.master_ok ? S_QRD : S_DONE;
        end else if (sts.scan_hit) begin
          state_nxt = (sts.func == FN_DEL) ? S_SHIFT_RD : S_DONE;
        end else if (sts.scan_miss) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_RD: state_nxt = sts.shift_more ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_QRD:      state_nxt = S_QOUT;
      S_QOUT:     state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        if (sts.func == FN_QUERY) begin
          cmd.res_nf = !sts.master_ok;
        end else if (sts.scan_hit) begin
          cmd.wr_upd  = (sts.func == FN_ADD);
          cmd.wr_set  = (sts.func == FN_SET);
          cmd.mv_init = (sts.func == FN_DEL);
        end else if (sts.scan_miss) begin
          if (sts.func == FN_ADD) begin
            cmd.res_full = sts.full;
            cmd.wr_new   = !sts.full;
          end else begin
            cmd.res_nf = 1'b1;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = sts.shift_more;
        cmd.dec      = !sts.shift_more;
      end
      S_SHIFT_WR: cmd.shift_wr = 1'b1;
      S_QRD:      cmd.q_rd = 1'b1;
      S_QOUT:     cmd.q_out = 1'b1;
      S_DONE:     cmd.out_load = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== sv/ddt_dp.sv =====
module ddt_dp
  import ddt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            in_func,
  input  logic [31:0]           in_comp_tag,
  input  logic [15:0]           in_dest_id,
  input  logic [1:0]            in_id_size,
  input  logic [7:0]            in_hop_count,
  input  logic                  in_is_master_port,
  input  logic [31:0]           in_flags_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [31:0]           out_comp_tag,
  output logic [15:0]           out_dest_id,
  output logic [1:0]            out_id_size,
  output logic [31:0]           out_flags
);

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_r;

  logic [31:0] ok_mask_r, mok_mask_r;

  logic [CNT_W-1:0] count_r, master_r, issue_r;
  logic [IDX_W-1:0] chk_r, mv_r;
  logic             pend_r;

  func_t       func_r;
  entry_t      key_r;

  status_t     res_status_r;
  logic [31:0] res_tag_r;
  logic [15:0] res_id_r;
  logic [1:0]  res_size_r;
  logic [31:0] res_flags_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_tag_r, out_flags_r;
  logic [15:0]      out_id_r;
  logic [1:0]       out_size_r;

  logic             match;
  logic [CNT_W-1:0] mv_next;
  logic [IDX_W-1:0] raddr, waddr;
  logic             we;
  entry_t           wdata;

  assign match   = (rdata_r.tag == key_r.tag) && (rdata_r.id == key_r.id);
  assign mv_next = CNT_W'(mv_r) + CNT_W'(1);

  always_comb begin
    sts.func       = func_r;
    sts.scan_hit   = pend_r && match;
    sts.scan_miss  = !(pend_r && match) && (issue_r == count_r);
    sts.full       = (count_r == CNT_W'(MAX_ENTRIES));
    sts.shift_more = (mv_next < count_r);
    sts.master_ok  = (master_r < count_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // one read address per cycle
  always_comb begin
    if (cmd.shift_rd) begin
      raddr = mv_next[IDX_W-1:0];
    end else if (cmd.q_rd) begin
      raddr = master_r[IDX_W-1:0];
    end else begin
      raddr = issue_r[IDX_W-1:0];
    end
  end

  always_comb begin
    we    = cmd.wr_upd || cmd.wr_set || cmd.wr_new || cmd.shift_wr;
    waddr = chk_r;
    wdata = rdata_r;
    if (cmd.wr_new) begin
      waddr = count_r[IDX_W-1:0];
      wdata = key_r;
    end else if (cmd.shift_wr) begin
      waddr = mv_r;
    end else if (cmd.wr_upd) begin
      wdata.size   = key_r.size;
      wdata.hops   = key_r.hops;
      wdata.master = key_r.master;
      wdata.flags  = rdata_r.flags | key_r.flags;
    end else if (cmd.wr_set) begin
      wdata.flags = key_r.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_mask_r  <= '0;
      mok_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OK_MASK:        ok_mask_r  <= cfg_data;
        CFG_MASTER_OK_MASK: mok_mask_r <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      master_r <= CNT_W'(MAX_ENTRIES);
      issue_r  <= '0;
      pend_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        issue_r <= '0;
        pend_r  <= 1'b0;
      end else if (cmd.scan) begin
        if (issue_r < count_r) begin
          issue_r <= issue_r + CNT_W'(1);
          pend_r  <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (cmd.wr_upd && key_r.master) begin
        master_r <= CNT_W'(chk_r);
      end
      if (cmd.wr_new) begin
        count_r <= count_r + CNT_W'(1);
        if (key_r.master) begin
          master_r <= count_r;
        end
      end
      if (cmd.dec) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // key, scan pointers and result staging
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r        <= func_t'(in_func);
      key_r.tag     <= in_comp_tag;
      key_r.id      <= in_dest_id;
      key_r.size    <= in_id_size;
      key_r.hops    <= in_hop_count;
      key_r.master  <= in_is_master_port;
      key_r.flags   <= in_flags_in;
      res_status_r  <= ST_OK;
      res_tag_r     <= '0;
      res_id_r      <= '0;
      res_size_r    <= '0;
      res_flags_r   <= '0;
    end
    if (cmd.scan) begin
      chk_r <= issue_r[IDX_W-1:0];
    end
    if (cmd.mv_init) begin
      mv_r <= chk_r;
    end else if (cmd.shift_wr) begin
      mv_r <= mv_next[IDX_W-1:0];
    end
    if (cmd.res_full) begin
      res_status_r <= ST_FULL;
    end
    if (cmd.res_nf) begin
      res_status_r <= ST_NOT_FOUND;
    end
    if (cmd.q_out) begin
      res_tag_r   <= rdata_r.tag;
      res_id_r    <= rdata_r.id;
      res_size_r  <= rdata_r.size;
      res_flags_r <= (rdata_r.flags & ~mok_mask_r) | ok_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_tag_r    <= res_tag_r;
      out_id_r     <= res_id_r;
      out_size_r   <= res_size_r;
      out_flags_r  <= res_flags_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_comp_tag = out_tag_r;
  assign out_dest_id  = out_id_r;
  assign out_id_size  = out_size_r;
  assign out_flags    = out_flags_r;

endmodule

// ===== sv/device_directory_table.sv =====
// channel  | role   | fields
// in_ch    | sink   | func, comp_tag, dest_id, id_size, hop_count, is_master_port, flags_in
// out_ch   | source | status, out_comp_tag, out_dest_id, out_id_size, out_flags
// cfg_*    | write  | cfg_we, cfg_index (0 ok mask, 1 master ok mask), cfg_data
//
// One word at a time. Key search reads one entry per cycle from the table
// RAM. A delete then moves each later entry down by one; a query reads the
// master entry directly and reports not found when there is no master.
// Reset: sync, active low; clears count and masks and sets the master index
// to MAX_ENTRIES (no master). Table RAM is not cleared, only entries below
// the count are read.
// out_ch holds a result while stalled; a new word is taken while it waits.
module device_directory_table
  import ddt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ddt_in_if.sink                in_ch,
  ddt_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  ddt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ddt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_func           (in_ch.func),
    .in_comp_tag       (in_ch.comp_tag),
    .in_dest_id        (in_ch.dest_id),
    .in_id_size        (in_ch.id_size),
    .in_hop_count      (in_ch.hop_count),
    .in_is_master_port (in_ch.is_master_port),
    .in_flags_in       (in_ch.flags_in),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_comp_tag      (out_ch.out_comp_tag),
    .out_dest_id       (out_ch.out_dest_id),
    .out_id_size       (out_ch.out_id_size),
    .out_flags         (out_ch.out_flags)
  );

endmodule
